/* rtl/rpfe_pkg.sv */
package rpfe_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [3:0] MODE_PASS     = 4'd0;
    localparam logic [3:0] MODE_BRIGHTEN = 4'd1;
    localparam logic [3:0] MODE_DARKEN   = 4'd2;
    localparam logic [3:0] MODE_CON_UP   = 4'd3;
    localparam logic [3:0] MODE_CON_DOWN = 4'd4;
    localparam logic [3:0] MODE_INVERT   = 4'd5;
    localparam logic [3:0] MODE_COLORIZE = 4'd6;
    localparam logic [3:0] MODE_GRAY     = 4'd7;
    localparam logic [3:0] MODE_SEPIA    = 4'd8;

    localparam logic [2:0] REG_MODE         = 3'd0;
    localparam logic [2:0] REG_AMOUNT       = 3'd1;
    localparam logic [2:0] REG_OFFSET_RED   = 3'd2;
    localparam logic [2:0] REG_OFFSET_GREEN = 3'd3;
    localparam logic [2:0] REG_OFFSET_BLUE  = 3'd4;

    localparam logic [7:0] SEPIA_RED   = 8'd100;
    localparam logic [7:0] SEPIA_GREEN = 8'd50;
    localparam logic [7:0] SEPIA_BLUE  = 8'd0;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } result_t;

    typedef struct packed {
        logic [3:0]        effect_mode;
        logic signed [8:0] amount;
        logic signed [8:0] offset_red;
        logic signed [8:0] offset_green;
        logic signed [8:0] offset_blue;
    } cfg_t;

endpackage

/* rtl/rpfe_regs.sv */
module rpfe_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpfe_pkg::PADDR_W-1:0] paddr,
    input  logic [rpfe_pkg::PDATA_W-1:0] pwdata,
    output logic [rpfe_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output rpfe_pkg::cfg_t               cfg
);
    import rpfe_pkg::*;

    logic [3:0]        mode_reg;
    logic signed [8:0] amount_reg;
    logic signed [8:0] off_red_reg;
    logic signed [8:0] off_green_reg;
    logic signed [8:0] off_blue_reg;
    logic [2:0]        index;
    logic              wr_en;

    assign index  = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_PASS;
            amount_reg    <= '0;
            off_red_reg   <= '0;
            off_green_reg <= '0;
            off_blue_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (index)
                REG_MODE:         mode_reg      <= pwdata[3:0];
                REG_AMOUNT:       amount_reg    <= signed'(pwdata[8:0]);
                REG_OFFSET_RED:   off_red_reg   <= signed'(pwdata[8:0]);
                REG_OFFSET_GREEN: off_green_reg <= signed'(pwdata[8:0]);
                REG_OFFSET_BLUE:  off_blue_reg  <= signed'(pwdata[8:0]);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_MODE:         prdata = {{(PDATA_W-4){1'b0}}, mode_reg};
            REG_AMOUNT:       prdata = {{(PDATA_W-9){amount_reg[8]}}, amount_reg};
            REG_OFFSET_RED:   prdata = {{(PDATA_W-9){off_red_reg[8]}}, off_red_reg};
            REG_OFFSET_GREEN: prdata = {{(PDATA_W-9){off_green_reg[8]}}, off_green_reg};
            REG_OFFSET_BLUE:  prdata = {{(PDATA_W-9){off_blue_reg[8]}}, off_blue_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.effect_mode  = mode_reg;
    assign cfg.amount       = amount_reg;
    assign cfg.offset_red   = off_red_reg;
    assign cfg.offset_green = off_green_reg;
    assign cfg.offset_blue  = off_blue_reg;

endmodule

/* rtl/rpfe_channel.sv */
module rpfe_channel (
    input  logic [7:0]        value,
    input  logic [3:0]        effect_mode,
    input  logic signed [8:0] amount,
    input  logic signed [8:0] offset,
    input  logic [7:0]        gray,
    input  logic [7:0]        tone,
    output logic [7:0]        res
);
    import rpfe_pkg::*;

    localparam logic signed [10:0] MID = 11'sd128;

    function automatic logic [7:0] clamp8(input logic signed [10:0] x);
        logic [7:0] r;
        if (x < 11'sd0)
            r = 8'd0;
        else if (x > 11'sd255)
            r = 8'd255;
        else
            r = x[7:0];
        return r;
    endfunction

    logic signed [10:0] v_s;
    logic signed [10:0] amt_s;
    logic signed [10:0] off_s;
    logic signed [10:0] t_add;
    logic signed [10:0] t_sub;
    logic signed [10:0] t_off;
    logic signed [10:0] t_tone;
    logic signed [10:0] up_t;
    logic signed [10:0] down_t;
    logic               low;

    assign v_s    = signed'({3'b000, value});
    assign amt_s  = {{2{amount[8]}}, amount};
    assign off_s  = {{2{offset[8]}}, offset};
    assign t_add  = v_s + amt_s;
    assign t_sub  = v_s - amt_s;
    assign t_off  = v_s + off_s;
    assign t_tone = signed'({3'b000, gray}) + signed'({3'b000, tone});
    assign low    = (value < 8'd128);

    always_comb
    begin
        if (low)
        begin
            up_t   = (t_sub > MID) ? MID : t_sub;
            down_t = (t_add > MID) ? MID : t_add;
        end
        else
        begin
            up_t   = (t_add < MID) ? MID : t_add;
            down_t = (t_sub < MID) ? MID : t_sub;
        end
    end

    always_comb
    begin
        case (effect_mode)
            MODE_BRIGHTEN: res = clamp8(t_add);
            MODE_DARKEN:   res = clamp8(t_sub);
            MODE_CON_UP:   res = clamp8(up_t);
            MODE_CON_DOWN: res = clamp8(down_t);
            MODE_INVERT:   res = ~value;
            MODE_COLORIZE: res = clamp8(t_off);
            MODE_GRAY:     res = gray;
            MODE_SEPIA:    res = clamp8(t_tone);
            default:       res = value;
        endcase
    end

endmodule

/* rtl/rpfe_effect.sv */
module rpfe_effect (
    input  rpfe_pkg::cfg_t    cfg,
    input  rpfe_pkg::pixel_t  pix,
    output rpfe_pkg::result_t res
);
    import rpfe_pkg::*;

    // (sum * 683) >> 11 equals sum / 3 for every sum up to 765
    localparam logic [19:0] GRAY_RECIP = 20'd683;
    localparam int          GRAY_SHIFT = 11;

    logic [9:0]  sum;
    logic [19:0] prod;
    logic [7:0]  gray;

    assign sum  = {2'b00, pix.red_in} + {2'b00, pix.green_in} + {2'b00, pix.blue_in};
    assign prod = {10'd0, sum} * GRAY_RECIP;
    assign gray = prod[GRAY_SHIFT+7:GRAY_SHIFT];

    rpfe_channel u_red (
        .value       (pix.red_in),
        .effect_mode (cfg.effect_mode),
        .amount      (cfg.amount),
        .offset      (cfg.offset_red),
        .gray        (gray),
        .tone        (SEPIA_RED),
        .res         (res.red_out)
    );

    rpfe_channel u_green (
        .value       (pix.green_in),
        .effect_mode (cfg.effect_mode),
        .amount      (cfg.amount),
        .offset      (cfg.offset_green),
        .gray        (gray),
        .tone        (SEPIA_GREEN),
        .res         (res.green_out)
    );

    rpfe_channel u_blue (
        .value       (pix.blue_in),
        .effect_mode (cfg.effect_mode),
        .amount      (cfg.amount),
        .offset      (cfg.offset_blue),
        .gray        (gray),
        .tone        (SEPIA_BLUE),
        .res         (res.blue_out)
    );

endmodule

/* rtl/rgb_point_effect_engine.sv */
// Point effect on an RGB pixel stream: pass, brighten, darken, contrast up/down, invert,
// colorize, gray and sepia, chosen by the effect_mode register. One pixel is taken every
// clock while pixel_ready is high; the pixel moves from the input register into the result
// register with the effect logic between the two, and its result is on the result port
// from the result register. Both registers hold under back-pressure, so up to two items
// are held while the result side stalls. Write the registers only while no item is in
// flight.
module rgb_point_effect_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpfe_pkg::PADDR_W-1:0] paddr,
    input  logic [rpfe_pkg::PDATA_W-1:0] pwdata,
    output logic [rpfe_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         pixel_valid,
    output logic                         pixel_ready,
    input  rpfe_pkg::pixel_t             pixel,
    output logic                         result_valid,
    input  logic                         result_ready,
    output rpfe_pkg::result_t            result
);
    import rpfe_pkg::*;

    cfg_t    cfg;
    pixel_t  pix_reg;
    pixel_t  pix_next;
    result_t res_reg;
    result_t res_next;
    result_t eff;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    logic    s2_valid_reg;
    logic    s2_valid_next;
    logic    s2_ready;

    rpfe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpfe_effect u_effect (
        .cfg (cfg),
        .pix (pix_reg),
        .res (eff)
    );

    assign s2_ready    = !s2_valid_reg || result_ready;
    assign pixel_ready = !s1_valid_reg || s2_ready;

    always_comb
    begin
        s1_valid_next = pixel_ready ? pixel_valid : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        pix_next      = (pixel_valid && pixel_ready) ? pixel : pix_reg;
        res_next      = (s1_valid_reg && s2_ready) ? eff : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        res_reg <= res_next;
    end

    assign result_valid = s2_valid_reg;
    assign result       = res_reg;

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> s1_valid_reg && s2_valid_reg)
        else $error("input blocked while a stage is empty");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_ready |=> s2_valid_reg)
        else $error("item lost between input and result register");

    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.effect_mode == MODE_GRAY |->
            eff.red_out == eff.green_out && eff.green_out == eff.blue_out)
        else $error("gray channels differ");

    a_invert: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.effect_mode == MODE_INVERT |->
            eff.red_out == ~pix_reg.red_in && eff.blue_out == ~pix_reg.blue_in)
        else $error("invert mismatch");

endmodule
